// ----- hw/rtl/rac_pkg.sv -----
// ----------------------------------------------------------------------------
// rac_pkg: shared types and constants of the rational accumulator ALU
// Operation codes, result status codes, sequencer states and fit limits.
// ----------------------------------------------------------------------------
package rac_pkg;

  // Configured result width; the accumulator and the result fields are
  // 32 bits, so anything wider behaves as 32.
  localparam int unsigned Width = 32;
  localparam int unsigned EffW  = (Width > 32) ? 32 : Width;

  // Largest positive magnitude and largest negative magnitude that fit.
  localparam logic [63:0] LimPos = (64'd1 << (EffW - 1)) - 64'd1;
  localparam logic [63:0] LimNeg = 64'd1 << (EffW - 1);

  typedef enum logic [3:0] {
    OpLoad     = 4'd0,
    OpAdd      = 4'd1,
    OpSub      = 4'd2,
    OpMul      = 4'd3,
    OpDiv      = 4'd4,
    OpPreInc   = 4'd5,
    OpPostInc  = 4'd6,
    OpPreDec   = 4'd7,
    OpPostDec  = 4'd8,
    OpNegate   = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroDen  = 2'd1,
    StDivZero  = 2'd2,
    StOverflow = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SMul0,
    SMul1,
    SMul2,
    SComb,
    SGcd,
    SDivN,
    SDivD,
    SCheck,
    SEmit
  } state_e;

endpackage

// ----- hw/rtl/rational_accumulator_alu_core.sv -----
// ----------------------------------------------------------------------------
// rational_accumulator_alu_core: rational number accumulator ALU
// Holds a reduced fraction and combines it with one operand fraction per
// transaction; sequencer around a shared multiplier, gcd and divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on the s_axis channel: tuser carries the
//   operation code, tdata the operand numerator and denominator. Each input
//   transaction yields exactly one output transaction on m_axis: tdata holds
//   the reduced numerator and the positive denominator, tuser the status.
//   One item is in flight at a time; s_axis_tready is high only while the
//   sequencer is idle. An item takes the shared 32x32 multiplier in the
//   steps SMul0, SMul1 and SMul2, then a combine step, a binary gcd (one
//   compare, subtract or shift per cycle), then two restoring divisions by
//   the odd part of the gcd, skipped when that odd part is one, then a check
//   step and an emit step. Undefined codes and divide by zero go straight
//   to the emit step. The result sits in an output register; the next item
//   is accepted while it waits, and a stalled receiver only holds the
//   sequencer at its last step. Reset clears the accumulator to 0/1 and
//   empties the output.
// ----------------------------------------------------------------------------
module rational_accumulator_alu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] operand_numerator,
                                      // [63:32] operand_denominator
  input  logic [3:0]  s_axis_tuser,   // [3:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] result_numerator,
                                      // [62:32] result_denominator, [63] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // Sequencer and operand registers
  rac_pkg::state_e  state_q, state_d;
  logic [3:0]       req_q, req_d;
  logic             on_q, on_d;           // operand sign
  logic [31:0]      om_q, om_d;           // operand numerator magnitude
  logic [31:0]      odm_q, odm_d;         // operand denominator magnitude
  rac_pkg::status_e st_q, st_d;           // pending zero-denominator status

  // Products of the shared multiplier
  logic [63:0]      p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;

  // Unreduced / reduced result in sign-magnitude form
  logic             rn_q, rn_d;
  logic [63:0]      rm_q, rm_d, rd_q, rd_d;

  // Binary gcd and restoring divider
  logic [63:0]      u_q, u_d, v_q, v_d;
  logic [5:0]       k_q, k_d;
  logic [63:0]      rem_q, rem_d, dq_q, dq_d;
  logic [5:0]       cnt_q, cnt_d;

  // Prepared result and new accumulator value
  logic [31:0]      res_num_q, res_num_d, nacc_num_q, nacc_num_d;
  logic [30:0]      res_den_q, res_den_d, nacc_den_q, nacc_den_d;
  rac_pkg::status_e res_st_q, res_st_d;
  logic             upd_q, upd_d;

  // Accumulator and output register
  logic [31:0]      acc_num_q, acc_num_d;
  logic [30:0]      acc_den_q, acc_den_d;
  logic             m_valid_q, m_valid_d;
  logic [31:0]      m_num_q, m_num_d;
  logic [30:0]      m_den_q, m_den_d;
  rac_pkg::status_e m_st_q, m_st_d;

  // Combinational helpers
  logic             a_neg;
  logic [31:0]      a_mag;
  logic [31:0]      a_den;
  logic             is_load, is_add, is_sub, is_mul, is_div;
  logic             is_inc, is_dec, is_post, is_neg;
  logic [31:0]      mul_x, mul_y;
  logic [63:0]      mul_p;
  logic             in_on, in_dn;
  logic [31:0]      in_om, in_odm;
  logic             sm_bn;
  logic [64:0]      rem_sh, rem_sub;
  logic             div_ge;
  logic [63:0]      rem_nx, dq_nx;
  logic [63:0]      mag_sh, den_sh;
  logic             fits;
  logic [31:0]      r_num;

  assign a_neg = acc_num_q[31];
  assign a_mag = a_neg ? (32'd0 - acc_num_q) : acc_num_q;
  assign a_den = {1'b0, acc_den_q};

  assign is_load = (req_q == rac_pkg::OpLoad);
  assign is_add  = (req_q == rac_pkg::OpAdd);
  assign is_sub  = (req_q == rac_pkg::OpSub);
  assign is_mul  = (req_q == rac_pkg::OpMul);
  assign is_div  = (req_q == rac_pkg::OpDiv);
  assign is_inc  = (req_q == rac_pkg::OpPreInc) || (req_q == rac_pkg::OpPostInc);
  assign is_dec  = (req_q == rac_pkg::OpPreDec) || (req_q == rac_pkg::OpPostDec);
  assign is_post = (req_q == rac_pkg::OpPostInc) || (req_q == rac_pkg::OpPostDec);
  assign is_neg  = (req_q == rac_pkg::OpNegate);

  // Shared multiplier: operand selection per step
  always_comb begin
    mul_x = 32'd0;
    mul_y = 32'd0;
    case (state_q)
      rac_pkg::SMul0: begin
        mul_x = is_load ? om_q : a_mag;
        mul_y = is_mul ? om_q : ((is_add || is_sub || is_div) ? odm_q : 32'd1);
      end
      rac_pkg::SMul1: begin
        mul_x = (is_add || is_sub) ? om_q : a_den;
        mul_y = (is_add || is_sub) ? a_den : 32'd1;
      end
      rac_pkg::SMul2: begin
        mul_x = is_load ? odm_q : a_den;
        mul_y = (is_add || is_sub || is_mul) ? odm_q : (is_div ? om_q : 32'd1);
      end
      default: begin
        mul_x = 32'd0;
        mul_y = 32'd0;
      end
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  // Input operand decode
  assign in_dn  = s_axis_tdata[63];
  assign in_odm = in_dn ? (32'd0 - s_axis_tdata[63:32]) : s_axis_tdata[63:32];
  assign in_om  = s_axis_tdata[31] ? (32'd0 - s_axis_tdata[31:0]) : s_axis_tdata[31:0];
  assign in_on  = (in_om != 32'd0) && (s_axis_tdata[31] ^ in_dn);

  // Sign of the second addend for add, sub, inc and dec
  assign sm_bn = is_add ? on_q : (is_sub ? ~on_q : is_dec);

  // One restoring division step
  assign rem_sh  = {rem_q, dq_q[63]};
  assign rem_sub = rem_sh - {1'b0, u_q};
  assign div_ge  = (rem_sh >= {1'b0, u_q});
  assign rem_nx  = div_ge ? rem_sub[63:0] : rem_sh[63:0];
  assign dq_nx   = {dq_q[62:0], div_ge};

  assign mag_sh = rm_q >> k_q;
  assign den_sh = rd_q >> k_q;

  assign fits  = (rd_q <= rac_pkg::LimPos) &&
                 (rn_q ? (rm_q <= rac_pkg::LimNeg) : (rm_q <= rac_pkg::LimPos));
  assign r_num = rn_q ? (32'd0 - rm_q[31:0]) : rm_q[31:0];

  assign s_axis_tready = (state_q == rac_pkg::SIdle);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    on_d       = on_q;
    om_d       = om_q;
    odm_d      = odm_q;
    st_d       = st_q;
    p0_d       = p0_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    rn_d       = rn_q;
    rm_d       = rm_q;
    rd_d       = rd_q;
    u_d        = u_q;
    v_d        = v_q;
    k_d        = k_q;
    rem_d      = rem_q;
    dq_d       = dq_q;
    cnt_d      = cnt_q;
    res_num_d  = res_num_q;
    res_den_d  = res_den_q;
    res_st_d   = res_st_q;
    upd_d      = upd_q;
    nacc_num_d = nacc_num_q;
    nacc_den_d = nacc_den_q;
    acc_num_d  = acc_num_q;
    acc_den_d  = acc_den_q;
    m_num_d    = m_num_q;
    m_den_d    = m_den_q;
    m_st_d     = m_st_q;
    m_valid_d  = m_valid_q && !m_axis_tready;

    case (state_q)
      rac_pkg::SIdle: begin
        if (s_axis_tvalid) begin
          req_d     = s_axis_tuser;
          upd_d     = 1'b0;
          res_num_d = acc_num_q;
          res_den_d = acc_den_q;
          if (in_odm == 32'd0) begin
            // Zero denominator: operand becomes 0/1
            on_d  = 1'b0;
            om_d  = 32'd0;
            odm_d = 32'd1;
            st_d  = (s_axis_tuser <= rac_pkg::OpDiv) ? rac_pkg::StZeroDen : rac_pkg::StOk;
          end else begin
            on_d  = in_on;
            om_d  = in_om;
            odm_d = in_odm;
            st_d  = rac_pkg::StOk;
          end
          if (s_axis_tuser > rac_pkg::OpNegate) begin
            res_st_d = rac_pkg::StOk;
            state_d  = rac_pkg::SEmit;
          end else if ((s_axis_tuser == rac_pkg::OpDiv) &&
                       ((in_odm == 32'd0) || (in_om == 32'd0))) begin
            res_st_d = rac_pkg::StDivZero;
            state_d  = rac_pkg::SEmit;
          end else begin
            state_d = rac_pkg::SMul0;
          end
        end
      end

      rac_pkg::SMul0: begin
        p0_d    = mul_p;
        state_d = rac_pkg::SMul1;
      end

      rac_pkg::SMul1: begin
        p1_d    = mul_p;
        state_d = rac_pkg::SMul2;
      end

      rac_pkg::SMul2: begin
        p2_d    = mul_p;
        state_d = rac_pkg::SComb;
      end

      rac_pkg::SComb: begin
        if (is_add || is_sub || is_inc || is_dec) begin
          if (a_neg == sm_bn) begin
            rn_d = a_neg;
            rm_d = p0_q + p1_q;
          end else if (p0_q >= p1_q) begin
            rn_d = a_neg;
            rm_d = p0_q - p1_q;
          end else begin
            rn_d = sm_bn;
            rm_d = p1_q - p0_q;
          end
        end else if (is_mul || is_div) begin
          rn_d = a_neg ^ on_q;
          rm_d = p0_q;
        end else if (is_load) begin
          rn_d = on_q;
          rm_d = p0_q;
        end else begin
          rn_d = ~a_neg;
          rm_d = p0_q;
        end
        rd_d = p2_q;
        u_d  = rm_d;
        v_d  = p2_q;
        k_d  = 6'd0;
        if (rm_d == 64'd0) begin
          // Zero result: canonical 0/1
          rn_d    = 1'b0;
          rd_d    = 64'd1;
          state_d = rac_pkg::SCheck;
        end else begin
          state_d = rac_pkg::SGcd;
        end
      end

      rac_pkg::SGcd: begin
        if (u_q == v_q) begin
          // gcd = u << k; strip the power of two, then divide by the odd part
          if (u_q == 64'd1) begin
            rm_d    = mag_sh;
            rd_d    = den_sh;
            state_d = rac_pkg::SCheck;
          end else begin
            dq_d    = mag_sh;
            rem_d   = 64'd0;
            cnt_d   = 6'd0;
            state_d = rac_pkg::SDivN;
          end
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 6'd1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q > v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end

      rac_pkg::SDivN: begin
        rem_d = rem_nx;
        dq_d  = dq_nx;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'h3F) begin
          rm_d    = dq_nx;
          dq_d    = den_sh;
          rem_d   = 64'd0;
          cnt_d   = 6'd0;
          state_d = rac_pkg::SDivD;
        end
      end

      rac_pkg::SDivD: begin
        rem_d = rem_nx;
        dq_d  = dq_nx;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'h3F) begin
          rd_d    = dq_nx;
          state_d = rac_pkg::SCheck;
        end
      end

      rac_pkg::SCheck: begin
        nacc_num_d = r_num;
        nacc_den_d = rd_q[30:0];
        if (!fits) begin
          res_num_d = acc_num_q;
          res_den_d = acc_den_q;
          res_st_d  = rac_pkg::StOverflow;
          upd_d     = 1'b0;
        end else if (is_neg) begin
          res_num_d = r_num;
          res_den_d = rd_q[30:0];
          res_st_d  = rac_pkg::StOk;
          upd_d     = 1'b0;
        end else if (is_post) begin
          res_num_d = acc_num_q;
          res_den_d = acc_den_q;
          res_st_d  = rac_pkg::StOk;
          upd_d     = 1'b1;
        end else begin
          res_num_d = r_num;
          res_den_d = rd_q[30:0];
          res_st_d  = st_q;
          upd_d     = 1'b1;
        end
        state_d = rac_pkg::SEmit;
      end

      rac_pkg::SEmit: begin
        // Hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_num_d   = res_num_q;
          m_den_d   = res_den_q;
          m_st_d    = res_st_q;
          if (upd_q) begin
            acc_num_d = nacc_num_q;
            acc_den_d = nacc_den_q;
          end
          state_d = rac_pkg::SIdle;
        end
      end

      default: begin
        state_d = rac_pkg::SIdle;
      end
    endcase
  end

  // Control state and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rac_pkg::SIdle;
      m_valid_q <= 1'b0;
      acc_num_q <= 32'd0;
      acc_den_q <= 31'd1;
      upd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
      upd_q     <= upd_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    on_q       <= on_d;
    om_q       <= om_d;
    odm_q      <= odm_d;
    st_q       <= st_d;
    p0_q       <= p0_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    rn_q       <= rn_d;
    rm_q       <= rm_d;
    rd_q       <= rd_d;
    u_q        <= u_d;
    v_q        <= v_d;
    k_q        <= k_d;
    rem_q      <= rem_d;
    dq_q       <= dq_d;
    cnt_q      <= cnt_d;
    res_num_q  <= res_num_d;
    res_den_q  <= res_den_d;
    res_st_q   <= res_st_d;
    nacc_num_q <= nacc_num_d;
    nacc_den_q <= nacc_den_d;
    m_num_q    <= m_num_d;
    m_den_q    <= m_den_d;
    m_st_q     <= m_st_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_den_q, m_num_q};
  assign m_axis_tuser  = m_st_q;

endmodule

// ----- verif/rational_accumulator_alu_core_tb.sv -----
// ----------------------------------------------------------------------------
// rational_accumulator_alu_core_tb: self-checking bench of the rational ALU
// Streams operation/operand transactions into the core, predicts each reduced
// fraction and status with an in-bench fraction model, and checks every
// output transaction in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module rational_accumulator_alu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned TotalRequests = 1600;
  localparam int unsigned PhaseItems    = 100;   // transactions per idling phase
  localparam int unsigned DrainCycles   = 500;   // worst gcd plus both divisions
  localparam int unsigned WatchdogLimit = 5000;  // quiet cycles before giving up
  localparam int unsigned MaxPrinted    = 50;

  // First code past negate, and the top of the 4-bit code space.
  localparam logic [3:0] FirstUndefOp = 4'(rac_pkg::OpNegate) + 4'd1;
  localparam logic [3:0] LastOpCode   = '1;

  localparam logic [31:0] IntMax = 32'h7FFF_FFFF;
  localparam logic [31:0] IntMin = 32'h8000_0000;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] num;
    logic [31:0] den;
  } frac_req_t;

  typedef struct {
    logic [31:0]      num;
    logic [30:0]      den;
    rac_pkg::status_e status;
  } frac_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;    // [31:0] operand_numerator,
                                     // [63:32] operand_denominator
  logic [3:0]  s_axis_tuser = '0;    // [3:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] result_numerator,
                                     // [62:32] result_denominator, [63] zero
  logic [1:0]  m_axis_tuser;         // [1:0] status

  // Accumulator copy of the predictor: 0/1 out of reset.
  logic [31:0] acc_num = 32'd0;
  logic [31:0] acc_den = 32'd1;

  frac_req_t    queued_requests[$];
  frac_result_t awaited_fractions[$];
  frac_req_t    next_req;
  frac_result_t want;

  int unsigned n_in = 0;        // accepted input transactions
  int unsigned n_out = 0;       // accepted output transactions
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_total;

  rational_accumulator_alu_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Magnitude of a 32-bit two's complement value, widened so that -2^31 fits.
  function automatic logic [63:0] magnitude(logic [31:0] bits);
    return bits[31] ? (64'h1_0000_0000 - {32'd0, bits}) : {32'd0, bits};
  endfunction

  // Build an output transaction from sign, magnitude and denominator.
  function automatic frac_result_t pack_fraction(logic neg, logic [63:0] mag,
                                                 logic [63:0] den,
                                                 rac_pkg::status_e st);
    frac_result_t r;
    r.num    = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    r.den    = den[30:0];
    r.status = st;
    return r;
  endfunction

  // Apply one request to the accumulator copy and return the output
  // transaction it should cause.
  function automatic frac_result_t rational_step(logic [3:0] op, logic [31:0] onum,
                                                 logic [31:0] oden);
    logic             a_neg, o_neg, d_neg, r_neg, b_neg, do_sum, fits;
    logic [63:0]      a_mag, a_den, o_mag, od_mag, r_mag, r_den, x, y, g, h, t;
    rac_pkg::status_e st;

    a_neg  = acc_num[31];
    a_mag  = magnitude(acc_num);
    a_den  = {32'd0, acc_den};
    do_sum = 1'b0;
    b_neg  = 1'b0;
    x      = '0;
    y      = '0;
    r_neg  = 1'b0;
    r_mag  = '0;
    r_den  = 64'd1;
    st     = rac_pkg::StOk;

    // Undefined codes only echo the accumulator.
    if (op > 4'(rac_pkg::OpNegate))
      return pack_fraction(a_neg, a_mag, a_den, rac_pkg::StOk);

    // Normalize the operand: zero denominator becomes 0/1, sign moves up.
    o_neg  = onum[31];
    o_mag  = magnitude(onum);
    d_neg  = oden[31];
    od_mag = magnitude(oden);
    if (od_mag == 0) begin
      o_neg  = 1'b0;
      o_mag  = '0;
      od_mag = 64'd1;
      if (op <= 4'(rac_pkg::OpDiv)) st = rac_pkg::StZeroDen;
    end else begin
      o_neg = (o_mag != 0) && (o_neg != d_neg);
    end

    case (op)
      rac_pkg::OpLoad: begin
        r_neg = o_neg;
        r_mag = o_mag;
        r_den = od_mag;
      end
      rac_pkg::OpAdd, rac_pkg::OpSub: begin
        do_sum = 1'b1;
        x      = a_mag * od_mag;
        y      = o_mag * a_den;
        b_neg  = (op == rac_pkg::OpSub) ? !o_neg : o_neg;
        r_den  = a_den * od_mag;
      end
      rac_pkg::OpMul: begin
        r_neg = a_neg ^ o_neg;
        r_mag = a_mag * o_mag;
        r_den = a_den * od_mag;
      end
      rac_pkg::OpDiv: begin
        if (o_mag == 0) return pack_fraction(a_neg, a_mag, a_den, rac_pkg::StDivZero);
        r_neg = a_neg ^ o_neg;
        r_mag = a_mag * od_mag;
        r_den = a_den * o_mag;
      end
      rac_pkg::OpPreInc, rac_pkg::OpPostInc, rac_pkg::OpPreDec, rac_pkg::OpPostDec: begin
        do_sum = 1'b1;
        x      = a_mag;
        y      = a_den;
        b_neg  = (op == rac_pkg::OpPreDec) || (op == rac_pkg::OpPostDec);
        r_den  = a_den;
      end
      default: begin
        r_neg = !a_neg;
        r_mag = a_mag;
        r_den = a_den;
      end
    endcase

    // Sign-magnitude sum of (a_neg, x) and (b_neg, y).
    if (do_sum) begin
      if (a_neg == b_neg) begin
        r_neg = a_neg;
        r_mag = x + y;
      end else if (x >= y) begin
        r_neg = a_neg;
        r_mag = x - y;
      end else begin
        r_neg = b_neg;
        r_mag = y - x;
      end
    end

    // Reduce by the gcd; zero always becomes 0/1.
    if (r_mag == 0) begin
      r_neg = 1'b0;
      r_den = 64'd1;
    end else begin
      g = r_mag;
      h = r_den;
      while (h != 0) begin
        t = g % h;
        g = h;
        h = t;
      end
      r_mag = r_mag / g;
      r_den = r_den / g;
    end

    fits = (r_den <= rac_pkg::LimPos) &&
           (r_neg ? (r_mag <= rac_pkg::LimNeg) : (r_mag <= rac_pkg::LimPos));
    if (!fits) return pack_fraction(a_neg, a_mag, a_den, rac_pkg::StOverflow);
    if (op == rac_pkg::OpNegate) return pack_fraction(r_neg, r_mag, r_den, rac_pkg::StOk);

    acc_num = r_neg ? (32'd0 - r_mag[31:0]) : r_mag[31:0];
    acc_den = r_den[31:0];
    if ((op == rac_pkg::OpPostInc) || (op == rac_pkg::OpPostDec))
      return pack_fraction(a_neg, a_mag, a_den, rac_pkg::StOk);
    return pack_fraction(r_neg, r_mag, r_den, st);
  endfunction

  // Idling percentage of either side for the current phase.
  function automatic int unsigned idle_pct(bit source_side);
    case ((n_in / PhaseItems) % 4)
      1:       return source_side ? 73 : 0;
      2:       return source_side ? 0 : 73;
      3:       return 38;
      default: return 0;
    endcase
  endfunction

  // Operand value: mostly small, some medium, full range and extremes.
  function automatic logic [31:0] rand_operand();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 60) begin
      v = 32'(int'($urandom_range(24)) - 12);
    end else if (sel < 80) begin
      v = 32'(int'($urandom_range(65535)) - 32768);
    end else if (sel < 90) begin
      v = $urandom();
    end else begin
      case ($urandom_range(5))
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = '1;
        3:       v = IntMax;
        4:       v = IntMin;
        default: v = IntMin + 32'd1;
      endcase
    end
    return v;
  endfunction

  task automatic push_req(logic [3:0] op, logic [31:0] num, logic [31:0] den);
    frac_req_t r;
    r.op  = op;
    r.num = num;
    r.den = den;
    queued_requests.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    if (n_errors < MaxPrinted)
      $display("%0t ns: output %0d %s: expected 0x%08h, got 0x%08h",
               $time, n_out, what, exp_val, got_val);
    n_errors++;
  endtask

  // Source side: predict on every accepted transaction, then present the
  // next request or idle, never dropping valid while a request waits.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_fractions.push_back(
          rational_step(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]));
        n_in <= n_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          next_req = queued_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_req.op;
          s_axis_tdata  <= {next_req.den, next_req.num};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each accepted result against the oldest prediction,
  // then decide whether to stall the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_out <= n_out + 1;
        if (awaited_fractions.size() == 0) begin
          report_mismatch("arrived with nothing pending, numerator", '0,
                          m_axis_tdata[31:0]);
        end else begin
          want = awaited_fractions.pop_front();
          if (m_axis_tdata[31:0] !== want.num)
            report_mismatch("numerator", want.num, m_axis_tdata[31:0]);
          if (m_axis_tdata[62:32] !== want.den)
            report_mismatch("denominator", {1'b0, want.den}, {1'b0, m_axis_tdata[62:32]});
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Abort when neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned run_len;

    // Directed: reduction and sign, zero operand denominator, every operation.
    push_req(rac_pkg::OpLoad,    32'd7,        32'd3);
    push_req(rac_pkg::OpLoad,    32'd6,        -32'sd4);      // reduces to -3/2
    push_req(rac_pkg::OpLoad,    32'd0,        -32'sd5);      // zero becomes 0/1
    push_req(rac_pkg::OpLoad,    32'd5,        32'd0);        // zero denominator
    push_req(rac_pkg::OpAdd,     32'd1,        32'd6);
    push_req(rac_pkg::OpSub,     32'd2,        32'd3);
    push_req(rac_pkg::OpAdd,     32'd9,        32'd0);        // zero denominator on add
    push_req(rac_pkg::OpMul,     -32'sd4,      32'd9);
    push_req(rac_pkg::OpDiv,     32'd3,        -32'sd2);
    push_req(rac_pkg::OpDiv,     32'd0,        32'd7);        // divide by zero
    push_req(rac_pkg::OpDiv,     32'd5,        32'd0);        // zero den, then div by zero
    push_req(rac_pkg::OpPreInc,  $urandom(),   $urandom());   // operand ignored
    push_req(rac_pkg::OpPostInc, $urandom(),   32'd0);        // never zero-den status
    push_req(rac_pkg::OpPreDec,  32'd0,        32'd0);
    push_req(rac_pkg::OpPostDec, IntMin,       IntMax);
    push_req(rac_pkg::OpNegate,  IntMax,       32'd0);
    push_req(FirstUndefOp, $urandom(), $urandom());  // undefined codes echo state
    push_req(LastOpCode,   $urandom(), 32'd0);
    // Overflow at the extremes.
    push_req(rac_pkg::OpLoad,    IntMax,       32'd1);
    push_req(rac_pkg::OpPreInc,  32'd0,        32'd0);        // overflow, state kept
    push_req(rac_pkg::OpPostInc, 32'd0,        32'd0);        // post overflow
    push_req(rac_pkg::OpMul,     IntMax,       32'd1);        // product overflow
    push_req(rac_pkg::OpLoad,    IntMin,       32'd1);
    push_req(rac_pkg::OpNegate,  32'd0,        32'd0);        // minus -2^31 does not fit
    push_req(rac_pkg::OpPostDec, 32'd0,        32'd0);
    push_req(rac_pkg::OpLoad,    32'd1,        IntMin);       // denominator 2^31 overflows
    push_req(rac_pkg::OpLoad,    IntMin,       IntMin);       // 1/1

    // Random: mostly a load followed by a run of operations, some noise.
    while (queued_requests.size() < TotalRequests) begin
      if ($urandom_range(99) < 85) begin
        push_req(rac_pkg::OpLoad, rand_operand(), rand_operand());
        run_len = $urandom_range(8, 2);
        repeat (run_len)
          push_req(4'($urandom_range(4'(rac_pkg::OpNegate))), rand_operand(),
                   rand_operand());
      end else begin
        push_req(4'($urandom_range(LastOpCode)), $urandom(), $urandom());
      end
    end
    n_total = queued_requests.size();

    // Hold reset for the first cycles, then release it on a clock edge.
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to arrive,
    // then allow the pipeline time to show any spurious output.
    while (n_in != n_total) @(posedge clk_i);
    while (n_out != n_in) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
